// File: rtl/mbps_pkg.sv
// Package: shared widths, register indexes, result kinds and record types for the pattern search.
`default_nettype none

package mbps_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_BYTES  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 3'd0,
        CFG_CARE_MASK      = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_STOP_AFTER     = 3'd3,
        CFG_BASE_ADDRESS   = 3'd4
    } t_cfg_index;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [PAT_BYTES*BYTE_W-1:0] pattern_bytes;
        logic [PAT_BYTES-1:0]        care_mask;
        logic [LEN_W-1:0]            pattern_length;
        logic [COUNT_W-1:0]          stop_after;
        logic [ADDR_W-1:0]           base_address;
    } t_cfg;

    // One record per input byte that causes results: a match, a summary, or both.
    typedef struct packed {
        logic                has_match;
        logic                has_end;
        logic [ADDR_W-1:0]   match_address;
        logic [COUNT_W-1:0]  match_total;
        logic [ADDR_W-1:0]   first_address;
    } t_rec;

endpackage

`default_nettype wire

// File: rtl/mbps_if.sv
// Interfaces: byte input channel and result output channel with valid/ready handshake.
`default_nettype none

interface mbps_in_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_range;

    modport source (output valid, output data_byte, output end_of_range, input ready);
    modport sink   (input valid, input data_byte, input end_of_range, output ready);
endinterface

interface mbps_out_if;
    import mbps_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [ADDR_W-1:0]  match_address;
    logic [COUNT_W-1:0] match_total;
    logic [ADDR_W-1:0]  first_address;
    logic               last;

    modport source (output valid, output kind, output match_address, output match_total,
                    output first_address, output last, input ready);
    modport sink   (input valid, input kind, input match_address, input match_total,
                    input first_address, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/masked_byte_pattern_search_top.sv
// Top level: configuration registers, scan stage and result queue of the masked byte pattern search.
//
//  channel   dir  handshake            payload
//  i_in      in   valid / ready        data_byte, end_of_range
//  o_out     out  valid / ready        kind, match_address, match_total, first_address, last
//  cfg       in   i_cfg_we             i_cfg_index, i_cfg_data
//
//  One byte per cycle while the output does not stall; a byte is compared in the cycle after it is
//  taken; its record is queued before it shows on o_out. A match and a summary of one byte need two
//  output transactions. Reset clears configuration and range state. Output stalls fill the
//  two-entry result queue, then hold the input register and i_in.ready.
`default_nettype none

module masked_byte_pattern_search_top #(
    parameter int PATTERN_LEN = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mbps_in_if.sink                              i_in,
    mbps_out_if.source                           o_out
);
    import mbps_pkg::*;

    t_cfg r_cfg;
    t_rec w_rec;
    logic w_rec_valid;
    logic w_rec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_BYTES: begin
                    r_cfg.pattern_bytes <= i_cfg_data;
                end
                CFG_CARE_MASK: begin
                    r_cfg.care_mask <= i_cfg_data[PAT_BYTES-1:0];
                end
                CFG_PATTERN_LENGTH: begin
                    r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                end
                CFG_STOP_AFTER: begin
                    r_cfg.stop_after <= i_cfg_data[COUNT_W-1:0];
                end
                CFG_BASE_ADDRESS: begin
                    r_cfg.base_address <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    mbps_scan #(
        .PATTERN_LEN (PATTERN_LEN)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec),
        .i_rec_ready (w_rec_ready)
    );

    mbps_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_rec_valid),
        .i_rec       (w_rec),
        .o_rec_ready (w_rec_ready),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    a_summary_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_SUMMARY))
            |-> (o_out.last && (o_out.match_address == '0)))
        else $error("summary without last or with nonzero address");

    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last)
            |=> (o_out.valid && (o_out.kind == KIND_SUMMARY)))
        else $error("match report with last low not followed by summary");

    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_MATCH))
            |-> ((o_out.match_total != '0) && (o_out.first_address <= o_out.match_address
                 || o_out.match_total != 32'd1)))
        else $error("match report with inconsistent count");

    a_rec_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rec_valid && !w_rec_ready) |=> $stable(w_rec))
        else $error("scan record changed while queue full");
`endif

endmodule

`default_nettype wire

// File: rtl/mbps_scan.sv
// Scan stage: input register, byte window, parallel masked compare and per-range counters.
`default_nettype none

module mbps_scan #(
    parameter int PATTERN_LEN = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mbps_pkg::t_cfg i_cfg,
    mbps_in_if.sink            i_in,
    output logic               o_rec_valid,
    output mbps_pkg::t_rec     o_rec,
    input  wire logic          i_rec_ready
);
    import mbps_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    logic [BYTE_W-1:0] r_win [PATTERN_LEN];
    logic [BYTE_W-1:0] w_win [PATTERN_LEN];

    logic [ADDR_W-1:0]  r_offset;
    logic [COUNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]  r_first;
    logic               r_stopped;

    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_len_m1;
    logic [PATTERN_LEN:1] w_len_hit;
    logic               w_win_match;
    logic               w_match;
    logic [ADDR_W-1:0]  w_addr;
    logic [COUNT_W-1:0] w_cnt;
    logic [ADDR_W-1:0]  w_first;
    logic               w_stop;
    logic               w_has_result;
    logic               w_advance;
    logic               w_accept;

    // Window after the held byte shifts in; slot 0 is the newest byte.
    always_comb begin
        w_win[0] = r_in_byte;
        for (int k = 1; k < PATTERN_LEN; k++) begin
            w_win[k] = r_win[k-1];
        end
    end

    assign w_len = (i_cfg.pattern_length > LEN_W'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN)
                                                                : i_cfg.pattern_length;
    assign w_len_m1 = w_len - LEN_W'(1);

    // One compare set per possible length, all over fixed window slots.
    always_comb begin
        logic hit;
        logic any;
        for (int l = 1; l <= PATTERN_LEN; l++) begin
            hit = 1'b1;
            any = 1'b0;
            for (int i = 0; i < l; i++) begin
                if (i_cfg.care_mask[i]) begin
                    any = 1'b1;
                    if (i_cfg.pattern_bytes[BYTE_W*i +: BYTE_W] != w_win[l-1-i]) begin
                        hit = 1'b0;
                    end
                end
            end
            w_len_hit[l] = hit && any;
        end
    end

    always_comb begin
        w_win_match = 1'b0;
        for (int l = 1; l <= PATTERN_LEN; l++) begin
            if (w_len == LEN_W'(l)) begin
                w_win_match = w_len_hit[l];
            end
        end
    end

    assign w_match = r_in_valid && !r_stopped && (w_len != '0)
                     && (r_offset >= ADDR_W'(w_len_m1)) && w_win_match;
    assign w_addr  = i_cfg.base_address + r_offset - ADDR_W'(w_len_m1);

    assign w_cnt   = !w_match ? r_cnt : ((r_cnt == '1) ? r_cnt : r_cnt + COUNT_W'(1));
    assign w_first = (w_match && (r_cnt == '0)) ? w_addr : r_first;
    assign w_stop  = r_stopped
                     || (w_match && (i_cfg.stop_after != '0) && (w_cnt >= i_cfg.stop_after));

    assign w_has_result = w_match || r_in_end;
    assign w_advance    = r_in_valid && (i_rec_ready || !w_has_result);
    assign w_accept     = i_in.valid && i_in.ready;
    assign i_in.ready   = !r_in_valid || w_advance;

    assign o_rec_valid         = r_in_valid && w_has_result;
    assign o_rec.has_match     = w_match;
    assign o_rec.has_end       = r_in_end;
    assign o_rec.match_address = w_addr;
    assign o_rec.match_total   = w_cnt;
    assign o_rec.first_address = w_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.end_of_range;
        end
        if (w_advance) begin
            r_win <= w_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_cnt     <= '0;
            r_first   <= '0;
            r_stopped <= 1'b0;
        end else if (w_advance) begin
            if (r_in_end) begin
                r_offset  <= '0;
                r_cnt     <= '0;
                r_first   <= '0;
                r_stopped <= 1'b0;
            end else begin
                r_offset  <= (r_offset == '1) ? r_offset : r_offset + ADDR_W'(1);
                r_cnt     <= w_cnt;
                r_first   <= w_first;
                r_stopped <= w_stop;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mbps_out.sv
// Result queue: two-entry record buffer that expands each record into one or two transactions.
`default_nettype none

module mbps_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_rec_valid,
    input  wire mbps_pkg::t_rec i_rec,
    output logic                o_rec_ready,
    mbps_out_if.source          o_out
);
    import mbps_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_phase;

    t_rec             w_head;
    logic             w_match_part;
    logic             w_fire;
    logic             w_pop;
    logic             w_push;

    assign w_head       = r_mem[r_rd_ptr];
    // Match part goes first; a record with both then gives its summary.
    assign w_match_part = w_head.has_match && !r_phase;

    assign o_out.valid         = (r_count != '0);
    assign o_out.kind          = w_match_part ? KIND_MATCH : KIND_SUMMARY;
    assign o_out.match_address = w_match_part ? w_head.match_address : '0;
    assign o_out.match_total   = w_head.match_total;
    assign o_out.first_address = w_head.first_address;
    assign o_out.last          = w_match_part ? !w_head.has_end : 1'b1;

    assign w_fire      = o_out.valid && o_out.ready;
    assign w_pop       = w_fire && o_out.last;
    assign o_rec_ready = (r_count != CNT_W'(DEPTH));
    assign w_push      = i_rec_valid && o_rec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_phase  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
            if (w_fire) begin
                r_phase <= !o_out.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the masked byte pattern search: directed and random ranges vs a local predictor.
`timescale 1ns / 1ps

module tb;
    import mbps_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1900;
    localparam int SETTLE       = 8;
    localparam int MAX_SHOWN    = 100;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  match_address;
        logic [COUNT_W-1:0] match_total;
        logic [ADDR_W-1:0]  first_address;
        logic               last;
    } t_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mbps_in_if  in_ch ();
    mbps_out_if out_ch ();

    masked_byte_pattern_search_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // predictor state
    t_cfg                cfg_now;
    logic [BYTE_W-1:0]   win_bytes [PAT_BYTES];
    logic [ADDR_W-1:0]   scan_offset;
    logic [COUNT_W-1:0]  hit_count;
    logic [ADDR_W-1:0]   first_hit;
    logic                hit_stopped;
    t_report             pending_reports [$];

    t_report head_report;
    int      err_count;
    int      items_sent;
    bit      sender_steady;
    bit      hold_req;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int active_length();
        return (cfg_now.pattern_length > PAT_BYTES) ? PAT_BYTES : int'(cfg_now.pattern_length);
    endfunction

    task automatic clear_scan();
        int i;
        for (i = 0; i < PAT_BYTES; i++) win_bytes[i] = '0;
        scan_offset = '0;
        hit_count   = '0;
        first_hit   = '0;
        hit_stopped = 1'b0;
    endtask

    task automatic add_report(input t_report rep);
        pending_reports.insert(pending_reports.size(), rep);
    endtask

    task automatic scan_byte_model(input logic [BYTE_W-1:0] b, input logic eor);
        int      len;
        int      i;
        logic    hit;
        logic    any_care;
        t_report rep;
        len = active_length();
        for (i = PAT_BYTES - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = b;
        hit      = (len > 0);
        any_care = 1'b0;
        for (i = 0; i < len; i++) begin
            if (cfg_now.care_mask[i]) begin
                any_care = 1'b1;
                if (cfg_now.pattern_bytes[8*i +: 8] != win_bytes[len-1-i]) hit = 1'b0;
            end
        end
        hit = hit && any_care;
        if (!hit_stopped && hit && scan_offset >= 64'(len - 1)) begin
            rep.match_address = cfg_now.base_address + (scan_offset - 64'(len - 1));
            if (hit_count == '0) first_hit = rep.match_address;
            if (hit_count != '1) hit_count++;
            if (cfg_now.stop_after != '0 && hit_count >= cfg_now.stop_after) hit_stopped = 1'b1;
            rep.kind          = KIND_MATCH;
            rep.match_total   = hit_count;
            rep.first_address = first_hit;
            rep.last          = !eor;
            add_report(rep);
        end
        if (scan_offset != '1) scan_offset++;
        if (eor) begin
            rep.kind          = KIND_SUMMARY;
            rep.match_address = '0;
            rep.match_total   = hit_count;
            rep.first_address = first_hit;
            rep.last          = 1'b1;
            add_report(rep);
            clear_scan();
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // called at a clock edge with the block idle
    task automatic apply_config(input logic [63:0] pat, input logic [7:0] care,
                                input logic [3:0] len, input logic [31:0] stop,
                                input logic [63:0] base);
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_CARE_MASK, 64'(care));
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        write_reg(CFG_STOP_AFTER, 64'(stop));
        write_reg(CFG_BASE_ADDRESS, base);
        i_cfg_we <= 1'b0;
        cfg_now.pattern_bytes  = pat;
        cfg_now.care_mask      = care;
        cfg_now.pattern_length = len;
        cfg_now.stop_after     = stop;
        cfg_now.base_address   = base;
        sender_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eor);
        int gap;
        int r;
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.end_of_range <= eor;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        scan_byte_model(b, eor);
        gap = 0;
        if (!sender_steady) begin
            r = $urandom_range(0, 99);
            if (r >= 95)      gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // bytes in address order from the low end of seq; the n-th one closes the range
    task automatic send_range(input logic [63:0] seq, input int n);
        int k;
        for (k = 0; k < n; k++) send_byte(seq[8*k +: 8], k == n - 1);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // planted copies of the pattern with random wildcard bytes, plus random and near-miss noise
    task automatic send_random_range(input int n);
        int               k;
        int               len;
        int               plant_pos;
        logic [BYTE_W-1:0] b;
        len       = active_length();
        plant_pos = -1;
        for (k = 0; k < n; k++) begin
            if (plant_pos < 0 && len > 0 && $urandom_range(0, 99) < 30) plant_pos = 0;
            if (plant_pos >= 0) begin
                b = cfg_now.care_mask[plant_pos] ? cfg_now.pattern_bytes[8*plant_pos +: 8]
                                                 : BYTE_W'($urandom);
                plant_pos++;
                if (plant_pos >= len) plant_pos = -1;
            end else if ($urandom_range(0, 1) == 0) begin
                b = BYTE_W'($urandom);
            end else begin
                b = cfg_now.pattern_bytes[8*$urandom_range(0, PAT_BYTES - 1) +: 8];
            end
            send_byte(b, k == n - 1);
        end
    endtask

    task automatic test_zero_length();
        apply_config(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'd0, 32'd0, 64'd0);
        send_range(64'h0000_0000_0000_FF00, 2);
        wait_idle();
    endtask

    task automatic test_exact_match();
        apply_config(64'h0000_0000_0000_A55A, 8'h03, 4'd2, 32'd0, 64'h1000);
        send_range(64'h0000_0000_A55A_A55A, 4);
        wait_idle();
    endtask

    task automatic test_wildcards();
        apply_config(64'h0000_0000_0033_2211, 8'h00, 4'd3, 32'd0, 64'd0);
        send_range(64'h0000_0000_0033_2211, 3);
        wait_idle();
        apply_config(64'h0000_0000_0033_0011, 8'h05, 4'd3, 32'd0, 64'h20);
        send_range(64'h0000_0000_0033_FF11, 3);
        wait_idle();
    endtask

    task automatic test_short_range();
        apply_config(64'd0, 8'h0F, 4'd4, 32'd0, 64'd0);
        send_range(64'd0, 2);
        wait_idle();
    endtask

    task automatic test_stop_after();
        apply_config(64'd0, 8'h01, 4'd1, 32'd1, 64'h40);
        send_range(64'd0, 3);
        wait_idle();
    endtask

    task automatic test_long_length_wrap();
        apply_config(64'h0123_4567_89AB_CDEF, 8'hFF, 4'd15, 32'hFFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 1'b0);
        send_range(64'h0123_4567_89AB_CDEF, 8);
        wait_idle();
    endtask

    task automatic test_output_hold();
        int k;
        apply_config(64'h0000_0000_0000_00AA, 8'h01, 4'd1, 32'd0, 64'h8000);
        sender_steady = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++)
            send_byte(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : 8'hAA, k == 39);
        wait_idle();
    endtask

    task automatic test_random_ranges();
        int            target;
        int            n_ranges;
        int            j;
        int            r;
        logic [63:0]   pat;
        logic [7:0]    care;
        logic [3:0]    len;
        logic [31:0]   stop;
        logic [63:0]   base;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            pat = {$urandom, $urandom};
            r = $urandom_range(0, 99);
            care = (r < 15) ? 8'h00 : (r < 40) ? 8'hFF : 8'($urandom);
            r = $urandom_range(0, 99);
            len = (r < 10) ? 4'd0 : (r < 20) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
            r = $urandom_range(0, 99);
            stop = (r < 65) ? 32'd0 : (r < 90) ? 32'($urandom_range(1, 4)) : 32'hFFFF_FFFF;
            r = $urandom_range(0, 99);
            base = (r < 20) ? 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15))
                 : (r < 30) ? 64'd0 : {$urandom, $urandom};
            apply_config(pat, care, len, stop, base);
            n_ranges = $urandom_range(1, 6);
            for (j = 0; j < n_ranges; j++)
                send_random_range(($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                               : $urandom_range(25, 120));
            wait_idle();
        end
    endtask

    // receiver: random stalls, steady stretches, and one long hold on request
    initial begin
        int r;
        int hold_count;
        int steady_left;
        out_ch.ready <= 1'b0;
        steady_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    steady_left = $urandom_range(30, 200);
                    out_ch.ready <= 1'b1;
                end else if (r < 65) begin
                    out_ch.ready <= 1'b1;
                end else if (r < 97) begin
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b0;
                    repeat ($urandom_range(8, 30)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_reports.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("%0t unexpected transaction: expected none actual kind %0h addr %0h",
                             $time, out_ch.kind, out_ch.match_address);
            end else begin
                head_report = pending_reports.pop_front();
                check_field("kind", 64'(head_report.kind), 64'(out_ch.kind));
                check_field("match_address", head_report.match_address, out_ch.match_address);
                check_field("match_total", 64'(head_report.match_total), 64'(out_ch.match_total));
                check_field("first_address", head_report.first_address, out_ch.first_address);
                check_field("last", 64'(head_report.last), 64'(out_ch.last));
            end
        end
    end

    initial begin
        err_count     = 0;
        items_sent    = 0;
        sender_steady = 1'b0;
        hold_req      = 1'b0;
        cfg_now       = '0;
        clear_scan();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_PATTERN_BYTES;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.end_of_range <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_length();
        test_exact_match();
        test_wildcards();
        test_short_range();
        test_stop_after();
        test_long_length_wrap();
        test_output_hold();
        test_random_ranges();

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
